/* rtl/rmst_pkg.sv */
// rmst_pkg: shared types and constants of the range minimum segment tree unit
// no dependencies; imported by every module of the block
`default_nettype none

package rmst_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // largest positive value, held by every node after the clearing sweep
  localparam logic signed [VALUE_W-1:0] TOP_VALUE = 32'sh7FFF_FFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_WUP    = 5'b00100,
    S_QLEFT  = 5'b01000,
    S_QRIGHT = 5'b10000
  } rmst_state_e;

endpackage : rmst_pkg

`default_nettype wire

/* rtl/rmst_node_ram.sv */
// rmst_node_ram: node store of the tree, one write port and one registered read port
// depends on rmst_pkg for the word width
`default_nettype none

module rmst_node_ram
  import rmst_pkg::*;
#(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [AW-1:0]             waddr_i,
  input  wire  signed [VALUE_W-1:0] wdata_i,
  input  wire  [AW-1:0]             raddr_i,
  output logic signed [VALUE_W-1:0] rdata_o
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : rmst_node_ram

`default_nettype wire

/* rtl/rmst_min_unit.sv */
// rmst_min_unit: the shared signed minimum, used by both the update walk and the query walk
// depends on rmst_pkg for the word width
`default_nettype none

module rmst_min_unit
  import rmst_pkg::*;
(
  input  wire  signed [VALUE_W-1:0] a_i,
  input  wire  signed [VALUE_W-1:0] b_i,
  output logic signed [VALUE_W-1:0] min_o
);

  assign min_o = (a_i <= b_i) ? a_i : b_i;

endmodule : rmst_min_unit

`default_nettype wire

/* rtl/range_min_segment_tree_unit.sv */
// range_min_segment_tree_unit: top level, sequencer around the node store and the min unit
// depends on rmst_pkg, rmst_node_ram and rmst_min_unit
`default_nettype none

// Usage
//   Command channel: op_i, index_lo_i, index_hi_i and value_i are taken at a rising edge
//   where start is high and busy is low. Each word gives exactly one result word on
//   min_value_o / status_o, marked by done_o for one cycle; the receiver cannot stall.
//   cfg_we_i writes cfg_wdata_i into the element count at any edge.
// Timing
//   A write walks from the leaf to the root, one level per cycle through the single min
//   unit, and gives its result word once the root has been refreshed.
//   A query climbs the tree in S_QLEFT and then S_QRIGHT at each level, one memory read
//   in each on the single read port.
//   An ignored write or an empty query gives its result in the cycle after accept.
//   busy is high for the whole walk; the next word can be taken once done_o rises.
// Reset
//   After reset the node store is swept to the largest positive value, one node per
//   cycle with busy high, until every node is cleared. The element count resets
//   to 1024; configuration writes are taken during the sweep.
module range_min_segment_tree_unit
  import rmst_pkg::*;
#(
  parameter int unsigned LEAVES = 1024
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire                       op_i,
  input  wire  [INDEX_W-1:0]        index_lo_i,
  input  wire  [INDEX_W-1:0]        index_hi_i,
  input  wire  signed [VALUE_W-1:0] value_i,
  output logic                      done_o,
  output logic signed [VALUE_W-1:0] min_value_o,
  output logic                      status_o,
  input  wire                       cfg_we_i,
  input  wire  [COUNT_W-1:0]        cfg_wdata_i
);

  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  // node pointers must also hold the end marker 2 * LEAVES
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (NW > COUNT_W) ? NW : COUNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  rmst_state_e state_q, state_d;
  logic [COUNT_W-1:0]        count_q;
  logic [AW-1:0]             clr_q, clr_d;
  logic [NW-1:0]             node_l_q, node_l_d;
  logic [NW-1:0]             node_r_q, node_r_d;
  logic signed [VALUE_W-1:0] acc_q, acc_d;
  logic                      pend_q, pend_d;
  logic                      done_q, done_d;
  logic signed [VALUE_W-1:0] min_value_q, min_value_d;
  logic                      status_q, status_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic signed [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic signed [VALUE_W-1:0] ram_rdata;
  logic signed [VALUE_W-1:0] min_res;

  logic              accept;
  logic [CMP_W-1:0]  leaves_c, count_c, n_use, n_last, lo_c, hi_c, hi_clip;
  logic              write_ok, query_empty;
  logic [NW-1:0]     leaf, r_start, parent, r_dec;
  logic [AW-1:0]     leaf_sib, parent_sib;

  rmst_node_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rmst_min_unit u_min (
    .a_i   (acc_q),
    .b_i   (ram_rdata),
    .min_o (min_res)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // clip the command against the elements in use
  assign leaves_c    = CMP_W'(LEAVES);
  assign count_c     = CMP_W'(count_q);
  assign lo_c        = CMP_W'(index_lo_i);
  assign hi_c        = CMP_W'(index_hi_i);
  assign n_use       = (count_c > leaves_c) ? leaves_c : count_c;
  assign n_last      = n_use - CMP_W'(1);
  assign hi_clip     = (hi_c > n_last) ? n_last : hi_c;
  assign write_ok    = (lo_c < n_use);
  assign query_empty = (n_use == '0) || (lo_c > hi_clip);

  assign leaf       = NW'(leaves_c + lo_c);
  assign r_start    = NW'(leaves_c + hi_clip + CMP_W'(1));
  assign leaf_sib   = {leaf[AW-1:1], ~leaf[0]};
  assign parent     = node_l_q >> 1;
  assign parent_sib = {parent[AW-1:1], ~parent[0]};
  assign r_dec      = node_r_q - NW'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_l_d    = node_l_q;
    node_r_d    = node_r_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    done_d      = 1'b0;
    min_value_d = min_value_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = TOP_VALUE;
    ram_raddr   = node_l_q[AW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_WRITE) begin
            if (write_ok) begin
              // leaf write and first sibling read share this cycle
              ram_we    = 1'b1;
              ram_waddr = leaf[AW-1:0];
              ram_wdata = value_i;
              ram_raddr = leaf_sib;
              acc_d     = value_i;
              node_l_d  = leaf;
              state_d   = S_WUP;
            end else begin
              done_d      = 1'b1;
              min_value_d = '0;
              status_d    = ST_IGNORED;
            end
          end else begin
            if (query_empty) begin
              done_d      = 1'b1;
              min_value_d = TOP_VALUE;
              status_d    = ST_DONE;
            end else begin
              node_l_d = leaf;
              node_r_d = r_start;
              acc_d    = TOP_VALUE;
              pend_d   = 1'b0;
              state_d  = S_QLEFT;
            end
          end
        end
      end
      S_WUP: begin
        // refresh the parent and fetch the parent's sibling for the next level
        ram_we    = 1'b1;
        ram_waddr = parent[AW-1:0];
        ram_wdata = min_res;
        ram_raddr = parent_sib;
        acc_d     = min_res;
        node_l_d  = parent;
        if (parent == NW'(1)) begin
          done_d      = 1'b1;
          min_value_d = '0;
          status_d    = ST_DONE;
          state_d     = S_IDLE;
        end
      end
      S_QLEFT: begin
        if (pend_q) begin
          acc_d = min_res;
        end
        if (node_l_q < node_r_q) begin
          ram_raddr = node_l_q[AW-1:0];
          pend_d    = node_l_q[0];
          node_l_d  = node_l_q + NW'(node_l_q[0]);
          state_d   = S_QRIGHT;
        end else begin
          done_d      = 1'b1;
          min_value_d = pend_q ? min_res : acc_q;
          status_d    = ST_DONE;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_QRIGHT: begin
        if (pend_q) begin
          acc_d = min_res;
        end
        ram_raddr = r_dec[AW-1:0];
        pend_d    = node_r_q[0];
        node_r_d  = node_r_q >> 1;
        node_l_d  = node_l_q >> 1;
        state_d   = S_QLEFT;
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= COUNT_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_l_q    <= node_l_d;
    node_r_q    <= node_r_d;
    acc_q       <= acc_d;
    min_value_q <= min_value_d;
    status_q    <= status_d;
  end

  assign done_o      = done_q;
  assign min_value_o = min_value_q;
  assign status_o    = status_q;

  // an accepted word is either still in the walk or already on the result ports
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted word neither in progress nor delivered");

  // ignored writes report a zero value
  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_IGNORED) |-> (min_value_o == '0))
    else $error("ignored write reported a nonzero value");

  // the update walk stays strictly below the root and inside the store
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WUP) |-> (node_l_q > NW'(1) && node_l_q < NW'(DEPTH)))
    else $error("update walk left the tree");

  // query window never inverts while walking up
  a_query_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QLEFT || state_q == S_QRIGHT) |-> (node_l_q <= node_r_q))
    else $error("query window inverted");

  // no result word appears while the store is being cleared
  a_no_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q != S_CLEAR))
    else $error("result word during clearing sweep");

endmodule : range_min_segment_tree_unit

`default_nettype wire
